// ----- src/wssu_pkg.sv -----
package wssu_pkg;

   localparam int WINDOW_DEF   = 32;
   localparam int CHANNELS_DEF = 2;

   localparam int MODE_W   = 2;
   localparam int COUNT_W  = 8;
   localparam int POS_W    = 10;
   localparam int SIZE_W   = 16;
   localparam int DIST_W   = 12;
   localparam int IDX_W    = 4;
   localparam int STAT_W   = 48;
   localparam int DATA_W   = 2 * POS_W + SIZE_W + 3 * DIST_W;
   localparam int Q_SHIFT  = 8;

   localparam int DIV_NUM_W = 64;
   localparam int DIV_STEP  = 4;

   localparam logic [MODE_W-1:0] MODE_COUNT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FULL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ADV   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_STATS = 2'd3;

   localparam logic [IDX_W-1:0] STAT_X_MEAN  = 4'd0;
   localparam logic [IDX_W-1:0] STAT_X_VAR   = 4'd1;
   localparam logic [IDX_W-1:0] STAT_Y_MEAN  = 4'd2;
   localparam logic [IDX_W-1:0] STAT_Y_VAR   = 4'd3;
   localparam logic [IDX_W-1:0] STAT_S_MEAN  = 4'd4;
   localparam logic [IDX_W-1:0] STAT_S_VAR   = 4'd5;
   localparam logic [IDX_W-1:0] STAT_S_MAX   = 4'd6;
   localparam logic [IDX_W-1:0] STAT_C_MEAN  = 4'd7;
   localparam logic [IDX_W-1:0] STAT_C_VAR   = 4'd8;
   localparam logic [IDX_W-1:0] STAT_N_VALID = 4'd9;
   localparam logic [IDX_W-1:0] STAT_DA_MEAN = 4'd10;
   localparam logic [IDX_W-1:0] STAT_DB_MEAN = 4'd11;
   localparam logic [IDX_W-1:0] STAT_DC_MEAN = 4'd12;
   localparam logic [IDX_W-1:0] STAT_WRAP    = 4'd13;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_PREP,
      ST_DSTART,
      ST_DWAIT,
      ST_EMIT
   } state_type;

endpackage

// ----- src/wssu_ram.sv -----
module wssu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/wssu_div.sv -----
module wssu_div import wssu_pkg::*; #(
   parameter int NUM_W = DIV_NUM_W,
   parameter int DEN_W = 18,
   parameter int STEP  = DIV_STEP
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int ITER  = NUM_W / STEP;
   localparam int CNT_W = $clog2(ITER + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W-1:0] rem_in;
   logic [NUM_W-1:0] quo_in;

   // STEP restoring steps per cycle while busy, quotient shifts in as dividend shifts out
   always_comb begin
      logic [DEN_W:0]   t;
      logic [DEN_W-1:0] r;
      logic [NUM_W-1:0] q;
      r = rem_ff;
      q = quo_ff;
      for (int j = 0; j < STEP; j++) begin
         t = {r, q[NUM_W-1]};
         q = {q[NUM_W-2:0], 1'b0};
         if (t >= {1'b0, den_ff}) begin
            t = t - {1'b0, den_ff};
            q[0] = 1'b1;
         end
         r = t[DEN_W-1:0];
      end
      rem_in = r;
      quo_in = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= num;
            den_ff  <= den;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ITER - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ----- src/windowed_sample_statistics_unit.sv -----
// Keeps a ring of WINDOW detection samples per channel in two block RAMs (object
// count, and position/size/distances). Count and full-sample writes go to the RAMs
// in the cycle they are accepted; an advance produces its single result. A
// statistics request walks the window one RAM read per cycle, then produces
// thirteen results through one shared divider that retires four quotient bits per
// cycle while busy; S_MAX, N_VALID and, when no sample is valid, all but the count
// statistics bypass it. req_stall stays high until the last result is taken, and
// output stalls hold the sequence. After reset all CHANNELS * WINDOW RAM entries
// are cleared one per cycle while req_stall is held high.
module windowed_sample_statistics_unit import wssu_pkg::*; #(
   parameter int WINDOW   = WINDOW_DEF,
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic               req_channel,
   input  logic [COUNT_W-1:0] req_obj_count,
   input  logic [POS_W-1:0]   req_center_x,
   input  logic [POS_W-1:0]   req_center_y,
   input  logic [SIZE_W-1:0]  req_blob_size,
   input  logic [DIST_W-1:0]  req_dist_a,
   input  logic [DIST_W-1:0]  req_dist_b,
   input  logic [DIST_W-1:0]  req_dist_c,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [IDX_W-1:0]   rsp_stat_index,
   output logic [STAT_W-1:0]  rsp_stat_value,
   output logic               rsp_last_item
);

   localparam int IW    = $clog2(WINDOW);
   localparam int CW    = $clog2(WINDOW + 1);
   localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH = CHANNELS * WINDOW;
   localparam int AW    = $clog2(DEPTH);
   localparam int XT_W  = POS_W + CW;
   localparam int XS_W  = 2 * POS_W + CW;
   localparam int ST_W  = SIZE_W + CW;
   localparam int SS_W  = 2 * SIZE_W + CW;
   localparam int CT_W  = COUNT_W + CW;
   localparam int CS_W  = 2 * COUNT_W + CW;
   localparam int DT_W  = DIST_W + CW;
   localparam int DIF_W = SS_W + CW;
   localparam int DEN_W = 2 * CW;

   state_type state_ff, state_in;

   logic [IW-1:0]     ptr_ff [CHANNELS];
   logic [AW-1:0]     clr_ff;
   logic [CW-1:0]     issue_ff;
   logic              rd_vld_ff;
   logic              sq_vld_ff;
   logic [AW-1:0]     base_ff;
   logic [IDX_W-1:0]  k_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [STAT_W-1:0] val_ff;
   logic              last_ff;

   logic              accept;
   logic              ok;
   logic [CHW-1:0]    cc;
   logic [AW-1:0]     base;
   logic [IW:0]       ptr_inc;
   logic              wrap;

   logic              cnt_we, dat_we;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;
   logic [DATA_W-1:0] dat_wdata, dat_rdata;
   logic              issuing;

   logic [COUNT_W-1:0]   c_ff;
   logic [2*COUNT_W-1:0] csq_ff;
   logic                 smp_ok_ff;
   logic [POS_W-1:0]     x_ff, y_ff;
   logic [2*POS_W-1:0]   xsq_ff, ysq_ff;
   logic [SIZE_W-1:0]    s_ff;
   logic [2*SIZE_W-1:0]  ssq_ff;
   logic [DIST_W-1:0]    da_ff, db_ff, dc_ff;

   logic [CW-1:0]     n_ff;
   logic [XT_W-1:0]   xt_ff, yt_ff;
   logic [XS_W-1:0]   xs_ff, ys_ff;
   logic [ST_W-1:0]   st_ff;
   logic [SS_W-1:0]   ss_ff;
   logic [CT_W-1:0]   ct_ff;
   logic [CS_W-1:0]   cs_ff;
   logic [DT_W-1:0]   da_t_ff, db_t_ff, dc_t_ff;
   logic [SIZE_W-1:0] mx_ff;

   logic [CW-1:0]        m_sel;
   logic [ST_W-1:0]      t_sel;
   logic [SS_W-1:0]      s2_sel;
   logic [DIF_W-1:0]     prod_a;
   logic [2*ST_W-1:0]    prod_b;
   logic [DIF_W-1:0]     diff;
   logic [DIV_NUM_W-1:0] num_in, num_ff;
   logic [DEN_W-1:0]     den_in, den_ff;
   logic                 bypass;
   logic [STAT_W-1:0]    bypass_val;

   logic                 div_start, div_done;
   logic [DIV_NUM_W-1:0] div_quot;

   assign accept  = req_valid && !req_stall;
   assign ok      = 32'(req_channel) < CHANNELS;
   assign cc      = ok ? CHW'(req_channel) : '0;
   assign base    = AW'(cc) * AW'(WINDOW);
   assign ptr_inc = {1'b0, ptr_ff[cc]} + (IW + 1)'(1);
   assign wrap    = ptr_inc == (IW + 1)'(WINDOW);
   assign issuing = (state_ff == ST_WALK) && (issue_ff != CW'(WINDOW));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_ADV) state_in = ST_EMIT;
               else if (req_mode == MODE_STATS) state_in = ok ? ST_WALK : ST_PREP;
            end
         end
         ST_WALK: begin
            if (!issuing && !rd_vld_ff && !sq_vld_ff) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = bypass ? ST_EMIT : ST_DSTART;
         end
         ST_DSTART: begin
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_stall) state_in = last_ff ? ST_IDLE : ST_PREP;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = state_ff != ST_IDLE;
      rsp_valid = state_ff == ST_EMIT;
      div_start = state_ff == ST_DSTART;
      cnt_we    = 1'b0;
      dat_we    = 1'b0;
      wr_addr   = base + AW'(ptr_ff[cc]);
      cnt_wdata = req_obj_count;
      dat_wdata = {req_dist_c, req_dist_b, req_dist_a, req_blob_size,
                   req_center_y, req_center_x};
      rd_addr   = base_ff + AW'(issue_ff[IW-1:0]);
      case (state_ff)
         ST_CLEAR: begin
            cnt_we    = 1'b1;
            dat_we    = 1'b1;
            wr_addr   = clr_ff;
            cnt_wdata = '0;
            dat_wdata = '0;
         end
         ST_IDLE: begin
            cnt_we = accept && ok && (req_mode == MODE_COUNT || req_mode == MODE_FULL);
            dat_we = accept && ok && (req_mode == MODE_FULL);
         end
         default: ;
      endcase
   end

   // statistic operand selection
   always_comb begin
      m_sel      = n_ff;
      t_sel      = ST_W'(xt_ff);
      s2_sel     = SS_W'(xs_ff);
      num_in     = '0;
      den_in     = DEN_W'(n_ff);
      bypass     = n_ff == '0;
      bypass_val = '0;
      case (k_ff)
         STAT_X_MEAN:  num_in = DIV_NUM_W'({xt_ff, 8'd0});
         STAT_Y_MEAN:  num_in = DIV_NUM_W'({yt_ff, 8'd0});
         STAT_S_MEAN:  num_in = DIV_NUM_W'({st_ff, 8'd0});
         STAT_Y_VAR: begin
            t_sel  = ST_W'(yt_ff);
            s2_sel = SS_W'(ys_ff);
         end
         STAT_S_VAR: begin
            t_sel  = st_ff;
            s2_sel = ss_ff;
         end
         STAT_S_MAX: begin
            bypass     = 1'b1;
            bypass_val = STAT_W'(mx_ff);
         end
         STAT_C_MEAN: begin
            m_sel  = CW'(WINDOW);
            num_in = DIV_NUM_W'({ct_ff, 8'd0});
            den_in = DEN_W'(WINDOW);
            bypass = 1'b0;
         end
         STAT_C_VAR: begin
            m_sel  = CW'(WINDOW);
            t_sel  = ST_W'(ct_ff);
            s2_sel = SS_W'(cs_ff);
            bypass = 1'b0;
         end
         STAT_N_VALID: begin
            bypass     = 1'b1;
            bypass_val = STAT_W'(n_ff);
         end
         STAT_DA_MEAN: num_in = DIV_NUM_W'(da_t_ff);
         STAT_DB_MEAN: num_in = DIV_NUM_W'(db_t_ff);
         STAT_DC_MEAN: num_in = DIV_NUM_W'(dc_t_ff);
         default: ;
      endcase
      prod_a = DIF_W'(m_sel) * DIF_W'(s2_sel);
      prod_b = t_sel * t_sel;
      diff   = prod_a - DIF_W'(prod_b);
      if (k_ff == STAT_X_VAR || k_ff == STAT_Y_VAR || k_ff == STAT_S_VAR ||
          k_ff == STAT_C_VAR) begin
         num_in = DIV_NUM_W'({diff, 8'd0});
         den_in = DEN_W'(m_sel) * DEN_W'(m_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         rd_vld_ff <= 1'b0;
         sq_vld_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) ptr_ff[i] <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issuing;
         sq_vld_ff <= rd_vld_ff;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (accept && ok && req_mode == MODE_ADV) begin
            ptr_ff[cc] <= wrap ? '0 : ptr_inc[IW-1:0];
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff  <= base;
         issue_ff <= '0;
         k_ff     <= STAT_X_MEAN;
         idx_ff   <= STAT_WRAP;
         val_ff   <= STAT_W'(ok && wrap);
         last_ff  <= 1'b1;
         n_ff     <= '0;
         xt_ff    <= '0;
         yt_ff    <= '0;
         xs_ff    <= '0;
         ys_ff    <= '0;
         st_ff    <= '0;
         ss_ff    <= '0;
         ct_ff    <= '0;
         cs_ff    <= '0;
         da_t_ff  <= '0;
         db_t_ff  <= '0;
         dc_t_ff  <= '0;
         mx_ff    <= '0;
      end
      if (issuing) issue_ff <= issue_ff + CW'(1);
      if (rd_vld_ff) begin
         c_ff      <= cnt_rdata;
         csq_ff    <= cnt_rdata * cnt_rdata;
         smp_ok_ff <= cnt_rdata != '0;
         x_ff      <= dat_rdata[POS_W-1:0];
         y_ff      <= dat_rdata[2*POS_W-1:POS_W];
         s_ff      <= dat_rdata[2*POS_W+SIZE_W-1:2*POS_W];
         xsq_ff    <= dat_rdata[POS_W-1:0] * dat_rdata[POS_W-1:0];
         ysq_ff    <= dat_rdata[2*POS_W-1:POS_W] * dat_rdata[2*POS_W-1:POS_W];
         ssq_ff    <= dat_rdata[2*POS_W+SIZE_W-1:2*POS_W]
                      * dat_rdata[2*POS_W+SIZE_W-1:2*POS_W];
         da_ff     <= dat_rdata[2*POS_W+SIZE_W+DIST_W-1:2*POS_W+SIZE_W];
         db_ff     <= dat_rdata[2*POS_W+SIZE_W+2*DIST_W-1:2*POS_W+SIZE_W+DIST_W];
         dc_ff     <= dat_rdata[DATA_W-1:2*POS_W+SIZE_W+2*DIST_W];
      end
      if (sq_vld_ff) begin
         ct_ff <= ct_ff + CT_W'(c_ff);
         cs_ff <= cs_ff + CS_W'(csq_ff);
         if (smp_ok_ff) begin
            n_ff    <= n_ff + CW'(1);
            xt_ff   <= xt_ff + XT_W'(x_ff);
            yt_ff   <= yt_ff + XT_W'(y_ff);
            xs_ff   <= xs_ff + XS_W'(xsq_ff);
            ys_ff   <= ys_ff + XS_W'(ysq_ff);
            st_ff   <= st_ff + ST_W'(s_ff);
            ss_ff   <= ss_ff + SS_W'(ssq_ff);
            da_t_ff <= da_t_ff + DT_W'(da_ff);
            db_t_ff <= db_t_ff + DT_W'(db_ff);
            dc_t_ff <= dc_t_ff + DT_W'(dc_ff);
            if (s_ff > mx_ff) mx_ff <= s_ff;
         end
      end
      if (state_ff == ST_PREP) begin
         num_ff  <= num_in;
         den_ff  <= den_in;
         idx_ff  <= k_ff;
         last_ff <= k_ff == STAT_DC_MEAN;
         val_ff  <= bypass_val;
      end
      if (state_ff == ST_DWAIT && div_done) val_ff <= div_quot[STAT_W-1:0];
      if (state_ff == ST_EMIT && !rsp_stall) k_ff <= k_ff + IDX_W'(1);
   end

   wssu_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (wr_addr),
      .wr_data (cnt_wdata),
      .rd_addr (rd_addr),
      .rd_data (cnt_rdata)
   );

   wssu_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_sample_ram (
      .clock   (clock),
      .wr_en   (dat_we),
      .wr_addr (wr_addr),
      .wr_data (dat_wdata),
      .rd_addr (rd_addr),
      .rd_data (dat_rdata)
   );

   wssu_div #(.NUM_W(DIV_NUM_W), .DEN_W(DEN_W), .STEP(DIV_STEP)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_stat_index = idx_ff;
   assign rsp_stat_value = val_ff;
   assign rsp_last_item  = last_ff;

endmodule
